@@ hdl/idsp_pkg.sv @@
// idsp_pkg: widths, event and action codes and register indexes of the
// idle disconnect suppression policy unit
// depends on nothing; used by the channel interfaces and the top level
package idsp_pkg;

   localparam int KIND_W = 3;
   localparam int TIME_W = 32;
   localparam int CFG_W = 31;
   localparam int ACTION_W = 2;
   localparam int COUNT_W = 32;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W = 32;

   typedef logic [KIND_W-1:0] kind_type;
   typedef logic [TIME_W-1:0] time_type;
   typedef logic [CFG_W-1:0] cfg_type;
   typedef logic [ACTION_W-1:0] action_type;
   typedef logic [COUNT_W-1:0] count_type;
   typedef logic [CSR_INDEX_W-1:0] csr_index_type;
   typedef logic [CSR_DATA_W-1:0] csr_data_type;

   // event codes
   localparam kind_type KIND_READY = 3'd0;
   localparam kind_type KIND_ACTIVITY = 3'd1;
   localparam kind_type KIND_ADVERT = 3'd2;
   localparam kind_type KIND_RECONNECT = 3'd3;
   localparam kind_type KIND_POLL = 3'd4;

   // poll decisions
   localparam action_type ACT_NONE = 2'd0;
   localparam action_type ACT_DISCONNECT = 2'd1;
   localparam action_type ACT_REARM = 2'd2;

   // register indexes
   localparam csr_index_type CSR_IDLE_TIMEOUT = 2'd0;
   localparam csr_index_type CSR_MAX_SUPPRESSION = 2'd1;
   localparam csr_index_type CSR_SLEEP_CONFIRM = 2'd2;

   // wrapping elapsed test: (now - since) mod 2^32 >= len
   function automatic logic elapsed(time_type now_t, time_type since, cfg_type len);
      time_type diff;
      diff = now_t - since;
      return diff >= {1'b0, len};
   endfunction

endpackage

@@ hdl/idsp_if.sv @@
// idsp channel interfaces: event request, result and register write channels
// depends on idsp_pkg
interface idsp_req_if;
   import idsp_pkg::*;
   logic valid;
   logic ready;
   kind_type kind;
   time_type now;
   logic session_up;
   modport source (output valid, output kind, output now, output session_up, input ready);
   modport sink (input valid, input kind, input now, input session_up, output ready);
endinterface

interface idsp_rsp_if;
   import idsp_pkg::*;
   logic valid;
   logic ready;
   action_type action;
   logic wake;
   logic peer_advertising;
   logic is_suppressed;
   logic asleep_confirmed;
   count_type disconnects;
   modport source (output valid, output action, output wake, output peer_advertising,
                   output is_suppressed, output asleep_confirmed, output disconnects,
                   input ready);
   modport sink (input valid, input action, input wake, input peer_advertising,
                 input is_suppressed, input asleep_confirmed, input disconnects,
                 output ready);
endinterface

interface idsp_csr_if;
   import idsp_pkg::*;
   logic valid;
   logic ready;
   csr_index_type index;
   csr_data_type data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

@@ hdl/idle_disconnect_suppression_policy_unit.sv @@
// idle_disconnect_suppression_policy_unit: link idle policy, one event in, one result out
// depends on idsp_pkg and the channel interfaces in idsp_if.sv
// a request passes the input register, then the result register, before its result is valid
// throughput: one event per cycle while results are taken; the policy state is updated as an event leaves
//   the input register, so the next event sees it without a bubble
// reset: synchronous, clears registers, timestamps, flags and the disconnect count
module idle_disconnect_suppression_policy_unit (
   input logic clock,
   input logic reset,
   idsp_req_if.sink req_if,
   idsp_rsp_if.source rsp_if,
   idsp_csr_if.sink csr_if
);
   import idsp_pkg::*;

   // configuration registers
   cfg_type idle_timeout_ff, max_suppression_ff, sleep_confirm_ff;

   // policy state
   time_type last_activity_ff, last_sighting_ff, suppress_start_ff;
   logic suppressed_ff, slept_ff, sighted_ff;
   count_type disconnect_count_ff;
   time_type last_activity_in, last_sighting_in, suppress_start_in;
   logic suppressed_in, slept_in, sighted_in;
   count_type disconnect_count_in;

   // input register
   logic s1_valid_ff;
   kind_type s1_kind_ff;
   time_type s1_now_ff;
   logic s1_up_ff;

   // result register
   logic rsp_valid_ff;
   action_type action_ff, action_in;
   logic wake_ff, wake_in;
   logic adv_ff, adv_in;
   logic suppressed_out_ff, slept_out_ff;
   count_type disconnects_ff;

   logic s1_advance;
   logic req_transfer;

   assign s1_advance = s1_valid_ff && (!rsp_valid_ff || rsp_if.ready);
   assign req_if.ready = !s1_valid_ff || s1_advance;
   assign req_transfer = req_if.valid && req_if.ready;
   assign csr_if.ready = 1'b1;

   // event decision and next policy state
   always_comb begin
      last_activity_in = last_activity_ff;
      last_sighting_in = last_sighting_ff;
      suppress_start_in = suppress_start_ff;
      suppressed_in = suppressed_ff;
      slept_in = slept_ff;
      sighted_in = sighted_ff;
      disconnect_count_in = disconnect_count_ff;
      action_in = ACT_NONE;
      wake_in = 1'b0;
      unique case (s1_kind_ff)
         KIND_READY, KIND_RECONNECT: begin
            last_activity_in = s1_now_ff;
            suppressed_in = 1'b0;
            slept_in = 1'b0;
         end
         KIND_ACTIVITY: begin
            last_activity_in = s1_now_ff;
         end
         KIND_ADVERT: begin
            wake_in = suppressed_ff && slept_ff;
            last_sighting_in = s1_now_ff;
            sighted_in = 1'b1;
            if (suppressed_ff && slept_ff) begin
               suppressed_in = 1'b0;
               slept_in = 1'b0;
            end
         end
         KIND_POLL: begin
            if (s1_up_ff) begin
               if (suppressed_ff) begin
                  suppressed_in = 1'b0;
                  slept_in = 1'b0;
                  last_activity_in = s1_now_ff;
               end else if (idle_timeout_ff != '0
                            && elapsed(s1_now_ff, last_activity_ff, idle_timeout_ff)) begin
                  suppressed_in = 1'b1;
                  slept_in = 1'b0;
                  suppress_start_in = s1_now_ff;
                  last_sighting_in = s1_now_ff;
                  sighted_in = 1'b1;
                  disconnect_count_in = disconnect_count_ff + count_type'(1);
                  action_in = ACT_DISCONNECT;
               end
            end else if (suppressed_ff) begin
               if (max_suppression_ff != '0
                   && elapsed(s1_now_ff, suppress_start_ff, max_suppression_ff)) begin
                  suppressed_in = 1'b0;
                  slept_in = 1'b0;
                  action_in = ACT_REARM;
               end else if (!slept_ff
                            && elapsed(s1_now_ff, last_sighting_ff, sleep_confirm_ff)) begin
                  slept_in = 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
      // advertising status after the event
      adv_in = sighted_in && !elapsed(s1_now_ff, last_sighting_in, sleep_confirm_ff);
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         idle_timeout_ff <= '0;
         max_suppression_ff <= '0;
         sleep_confirm_ff <= '0;
      end else if (csr_if.valid) begin
         unique case (csr_if.index)
            CSR_IDLE_TIMEOUT: idle_timeout_ff <= csr_if.data[CFG_W-1:0];
            CSR_MAX_SUPPRESSION: max_suppression_ff <= csr_if.data[CFG_W-1:0];
            CSR_SLEEP_CONFIRM: sleep_confirm_ff <= csr_if.data[CFG_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_if.ready) begin
         s1_valid_ff <= req_if.valid;
      end
      if (req_transfer) begin
         s1_kind_ff <= req_if.kind;
         s1_now_ff <= req_if.now;
         s1_up_ff <= req_if.session_up;
      end
   end

   // policy state update as an event moves to the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         last_activity_ff <= '0;
         last_sighting_ff <= '0;
         suppress_start_ff <= '0;
         suppressed_ff <= 1'b0;
         slept_ff <= 1'b0;
         sighted_ff <= 1'b0;
         disconnect_count_ff <= '0;
      end else if (s1_advance) begin
         last_activity_ff <= last_activity_in;
         last_sighting_ff <= last_sighting_in;
         suppress_start_ff <= suppress_start_in;
         suppressed_ff <= suppressed_in;
         slept_ff <= slept_in;
         sighted_ff <= sighted_in;
         disconnect_count_ff <= disconnect_count_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (s1_advance) begin
         action_ff <= action_in;
         wake_ff <= wake_in;
         adv_ff <= adv_in;
         suppressed_out_ff <= suppressed_in;
         slept_out_ff <= slept_in;
         disconnects_ff <= disconnect_count_in;
      end
   end

   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.action = action_ff;
   assign rsp_if.wake = wake_ff;
   assign rsp_if.peer_advertising = adv_ff;
   assign rsp_if.is_suppressed = suppressed_out_ff;
   assign rsp_if.asleep_confirmed = slept_out_ff;
   assign rsp_if.disconnects = disconnects_ff;

endmodule

@@ tb/tb_idle_disconnect_suppression_policy_unit.sv @@
// tb_idle_disconnect_suppression_policy_unit: self-checking bench for the link idle policy
// unit: a directed event table and random event traffic, scored by a local policy predictor
// depends on idsp_pkg, the channel interfaces in idsp_if.sv and the unit itself
`timescale 1ns / 1ps

module tb_idle_disconnect_suppression_policy_unit;
   import idsp_pkg::*;

   // event codes the unit has no meaning for, register slot with no register behind it
   localparam kind_type KIND_SPARE_LO = 3'd5;
   localparam kind_type KIND_SPARE_MID = 3'd6;
   localparam kind_type KIND_SPARE_HI = 3'd7;
   localparam csr_index_type CSR_SPARE = 2'd3;

   localparam int PHASE_ITEMS = 320;
   localparam int PHASES = 4;
   // leave plenty of room for the slowest legal run
   localparam int CYCLE_LIMIT = 200000;
   localparam int PRINT_CAP = 100;

   typedef struct packed {
      action_type action;
      logic wake;
      logic peer_advertising;
      logic is_suppressed;
      logic asleep_confirmed;
      count_type disconnects;
   } verdict_type;

   typedef struct packed {
      time_type last_activity;
      time_type last_sighting;
      time_type suppress_start;
      logic suppressed;
      logic slept;
      logic sighted;
      count_type disconnects;
   } link_state_type;

   typedef struct packed {
      kind_type kind;
      time_type now;
      logic session_up;
      logic pinned;
      verdict_type want;
   } script_row_type;

   localparam verdict_type QUIET = '0;
   localparam int SCRIPT_LEN = 25;
   localparam int RESET_ROWS = 9;

   // directed events; the first rows run with all registers still at zero
   localparam script_row_type SCRIPT [SCRIPT_LEN] = '{
      '{KIND_READY, 32'h0000_0000, 1'b1, 1'b1, QUIET},
      '{KIND_SPARE_LO, 32'hFFFF_FFFF, 1'b1, 1'b1, QUIET},
      '{KIND_SPARE_MID, 32'h0000_0000, 1'b0, 1'b1, QUIET},
      '{KIND_SPARE_HI, 32'h8000_0000, 1'b1, 1'b1, QUIET},
      '{KIND_POLL, 32'hFFFF_FFFF, 1'b1, 1'b1, QUIET},
      '{KIND_POLL, 32'h0000_0000, 1'b0, 1'b1, QUIET},
      '{KIND_ADVERT, 32'hFFFF_FFFF, 1'b1, 1'b1, QUIET},
      '{KIND_ACTIVITY, 32'h1234_5678, 1'b1, 1'b1, QUIET},
      '{KIND_RECONNECT, 32'h0000_0000, 1'b0, 1'b1, QUIET},
      // idle 100, max suppression 1000, sleep confirm 50 from here on
      '{KIND_ACTIVITY, 32'hFFFF_FFF0, 1'b0, 1'b0, QUIET},
      '{KIND_POLL, 32'h0000_0050, 1'b1, 1'b0, QUIET},
      '{KIND_POLL, 32'h0000_0054, 1'b1, 1'b1,
        '{ACT_DISCONNECT, 1'b0, 1'b1, 1'b1, 1'b0, 32'd1}},
      '{KIND_ADVERT, 32'h0000_0060, 1'b1, 1'b0, QUIET},
      '{KIND_SPARE_HI, 32'h0000_0070, 1'b0, 1'b0, QUIET},
      '{KIND_POLL, 32'h0000_0080, 1'b0, 1'b0, QUIET},
      '{KIND_POLL, 32'h0000_0092, 1'b0, 1'b0, QUIET},
      '{KIND_ADVERT, 32'h0000_00A0, 1'b0, 1'b0, QUIET},
      '{KIND_POLL, 32'h0000_00A0, 1'b1, 1'b0, QUIET},
      '{KIND_POLL, 32'h0000_00B0, 1'b1, 1'b0, QUIET},
      '{KIND_POLL, 32'h0000_1000, 1'b1, 1'b0, QUIET},
      '{KIND_POLL, 32'h0000_13E7, 1'b0, 1'b0, QUIET},
      '{KIND_POLL, 32'h0000_13E8, 1'b0, 1'b1,
        '{ACT_REARM, 1'b0, 1'b0, 1'b0, 1'b0, 32'd3}},
      '{KIND_POLL, 32'h0000_13E9, 1'b0, 1'b0, QUIET},
      '{KIND_RECONNECT, 32'h0000_2000, 1'b1, 1'b0, QUIET},
      '{KIND_READY, 32'hFFFF_FFFF, 1'b1, 1'b0, QUIET}
   };

   logic clock;
   logic reset;

   idsp_req_if evt_ch ();
   idsp_rsp_if res_ch ();
   idsp_csr_if csr_ch ();

   idle_disconnect_suppression_policy_unit dut (
      .clock(clock),
      .reset(reset),
      .req_if(evt_ch),
      .rsp_if(res_ch),
      .csr_if(csr_ch)
   );

   // predictor copy of the policy state and registers
   link_state_type link_st = '0;
   cfg_type idle_len = '0;
   cfg_type suppress_len = '0;
   cfg_type sleep_len = '0;

   verdict_type pending_q [$];
   verdict_type head;

   int error_count = 0;
   int sent_count = 0;
   int checked_count = 0;
   int cycle_count = 0;
   int disconnect_seen = 0;
   int rearm_seen = 0;
   int wake_seen = 0;

   int send_idle_pct = 0;
   int stall_pct = 0;
   int rsp_hold_cycles = 0;
   int unsigned step_cap = 40;
   time_type wall = '0;

   // clock, 2 ns period
   initial clock = 1'b0;
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                  pending_q.size());
         $display("tb_idle_disconnect_suppression_policy_unit failed");
         $finish;
      end
   end

   // wrapping interval test on millisecond timestamps
   function automatic logic interval_done(time_type t, time_type since, cfg_type len);
      return time_type'(t - since) >= time_type'(len);
   endfunction

   // advances the predicted policy state by one event and returns its result
   function automatic verdict_type policy_step(kind_type k, time_type t, logic up);
      verdict_type v;
      v = '0;
      case (k)
         KIND_READY, KIND_RECONNECT: begin
            link_st.last_activity = t;
            link_st.suppressed = 1'b0;
            link_st.slept = 1'b0;
         end
         KIND_ACTIVITY: begin
            link_st.last_activity = t;
         end
         KIND_ADVERT: begin
            v.wake = link_st.suppressed && link_st.slept;
            link_st.last_sighting = t;
            link_st.sighted = 1'b1;
            if (v.wake) begin
               link_st.suppressed = 1'b0;
               link_st.slept = 1'b0;
            end
         end
         KIND_POLL: begin
            if (up) begin
               // session back while suppressed clears suppression
               if (link_st.suppressed) begin
                  link_st.suppressed = 1'b0;
                  link_st.slept = 1'b0;
                  link_st.last_activity = t;
               end else if (idle_len != '0 &&
                            interval_done(t, link_st.last_activity, idle_len)) begin
                  link_st.suppressed = 1'b1;
                  link_st.slept = 1'b0;
                  link_st.suppress_start = t;
                  link_st.last_sighting = t;
                  link_st.sighted = 1'b1;
                  link_st.disconnects = link_st.disconnects + count_type'(1);
                  v.action = ACT_DISCONNECT;
               end
            end else if (link_st.suppressed) begin
               if (suppress_len != '0 &&
                   interval_done(t, link_st.suppress_start, suppress_len)) begin
                  link_st.suppressed = 1'b0;
                  link_st.slept = 1'b0;
                  v.action = ACT_REARM;
               end else if (!link_st.slept &&
                            interval_done(t, link_st.last_sighting, sleep_len)) begin
                  link_st.slept = 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
      v.peer_advertising = link_st.sighted &&
                           !interval_done(t, link_st.last_sighting, sleep_len);
      v.is_suppressed = link_st.suppressed;
      v.asleep_confirmed = link_st.slept;
      v.disconnects = link_st.disconnects;
      return v;
   endfunction

   task automatic log_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
      error_count++;
      if (error_count <= PRINT_CAP)
         $display("[%0t] result %0d %s: got %0h expected %0h", $time, checked_count, what,
                  got, want);
   endtask

   // register write transfer; the predictor keeps only what the register holds
   task automatic write_register(input csr_index_type idx, input csr_data_type value);
      @(negedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data <= value;
      do @(posedge clock); while (!csr_ch.ready);
      case (idx)
         CSR_IDLE_TIMEOUT: idle_len = value[CFG_W-1:0];
         CSR_MAX_SUPPRESSION: suppress_len = value[CFG_W-1:0];
         CSR_SLEEP_CONFIRM: sleep_len = value[CFG_W-1:0];
         default: begin
         end
      endcase
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   // one event transfer, with random sender gaps ahead of it
   task automatic send_event(input kind_type k, input time_type t, input logic up,
                             input logic pinned, input verdict_type pinned_want);
      verdict_type v;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         @(negedge clock);
         evt_ch.valid <= 1'b0;
      end
      @(negedge clock);
      evt_ch.valid <= 1'b1;
      evt_ch.kind <= k;
      evt_ch.now <= t;
      evt_ch.session_up <= up;
      do @(posedge clock); while (!evt_ch.ready);
      v = policy_step(k, t, up);
      if (v.action == ACT_DISCONNECT) disconnect_seen++;
      if (v.action == ACT_REARM) rearm_seen++;
      if (v.wake) wake_seen++;
      pending_q.push_back(pinned ? pinned_want : v);
      sent_count++;
   endtask

   // stop offering and wait until every result is back; returns on a rising edge
   task automatic drain_results();
      @(negedge clock);
      evt_ch.valid <= 1'b0;
      do @(posedge clock); while (pending_q.size() != 0);
   endtask

   function automatic kind_type pick_kind();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 38) return KIND_POLL;
      if (r < 53) return KIND_ACTIVITY;
      if (r < 70) return KIND_ADVERT;
      if (r < 78) return KIND_READY;
      if (r < 86) return KIND_RECONNECT;
      return kind_type'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
   endfunction

   // timestamps most often creep forward, often land right on a threshold edge,
   // sometimes repeat and sometimes jump anywhere
   function automatic time_type pick_now();
      int unsigned r;
      time_type base;
      cfg_type len;
      time_type t;
      r = $urandom_range(0, 99);
      if (r < 45) begin
         t = wall + time_type'($urandom_range(0, step_cap));
      end else if (r < 75) begin
         case ($urandom_range(0, 2))
            0: begin
               base = link_st.last_activity;
               len = idle_len;
            end
            1: begin
               base = link_st.suppress_start;
               len = suppress_len;
            end
            default: begin
               base = link_st.last_sighting;
               len = sleep_len;
            end
         endcase
         t = base + time_type'(len) + time_type'($urandom_range(0, 2)) - time_type'(1);
      end else if (r < 90) begin
         t = wall;
      end else begin
         t = $urandom;
      end
      wall = t;
      return t;
   endfunction

   // result checker
   always @(posedge clock) begin
      if (!reset && res_ch.valid && res_ch.ready) begin
         if (pending_q.size() == 0) begin
            log_mismatch("unexpected result, disconnects", res_ch.disconnects, '0);
         end else begin
            head = pending_q.pop_front();
            if (res_ch.action !== head.action)
               log_mismatch("action", 32'(res_ch.action), 32'(head.action));
            if (res_ch.wake !== head.wake)
               log_mismatch("wake", 32'(res_ch.wake), 32'(head.wake));
            if (res_ch.peer_advertising !== head.peer_advertising)
               log_mismatch("peer_advertising", 32'(res_ch.peer_advertising),
                            32'(head.peer_advertising));
            if (res_ch.is_suppressed !== head.is_suppressed)
               log_mismatch("is_suppressed", 32'(res_ch.is_suppressed),
                            32'(head.is_suppressed));
            if (res_ch.asleep_confirmed !== head.asleep_confirmed)
               log_mismatch("asleep_confirmed", 32'(res_ch.asleep_confirmed),
                            32'(head.asleep_confirmed));
            if (res_ch.disconnects !== head.disconnects)
               log_mismatch("disconnects", res_ch.disconnects, head.disconnects);
         end
         checked_count++;
      end
   end

   // result receiver: long hold when asked, random stalls otherwise
   initial begin
      res_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (reset) begin
            res_ch.ready <= 1'b0;
         end else if (rsp_hold_cycles > 0) begin
            res_ch.ready <= 1'b0;
            rsp_hold_cycles--;
         end else begin
            res_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
         end
      end
   end

   // event sender and run control
   initial begin
      kind_type k;
      time_type t;
      reset = 1'b1;
      evt_ch.valid = 1'b0;
      evt_ch.kind = KIND_READY;
      evt_ch.now = '0;
      evt_ch.session_up = 1'b0;
      csr_ch.valid = 1'b0;
      csr_ch.index = CSR_IDLE_TIMEOUT;
      csr_ch.data = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table, reset register values first
      for (int i = 0; i < SCRIPT_LEN; i++) begin
         if (i == RESET_ROWS) begin
            drain_results();
            // upper bit of each write is dropped by the 31-bit registers
            write_register(CSR_IDLE_TIMEOUT, 32'h8000_0064);
            write_register(CSR_MAX_SUPPRESSION, 32'h8000_03E8);
            write_register(CSR_SLEEP_CONFIRM, 32'h0000_0032);
            write_register(CSR_SPARE, 32'hFFFF_FFFF);
         end
         send_event(SCRIPT[i].kind, SCRIPT[i].now, SCRIPT[i].session_up, SCRIPT[i].pinned,
                    SCRIPT[i].want);
      end
      wall = SCRIPT[SCRIPT_LEN-1].now;

      // random traffic, one register setting and idle pattern per phase
      for (int p = 0; p < PHASES; p++) begin
         drain_results();
         case (p)
            0: begin
               send_idle_pct = 0;
               stall_pct = 0;
               step_cap = 40;
               rsp_hold_cycles = 300;
               write_register(CSR_IDLE_TIMEOUT, 32'd100);
               write_register(CSR_MAX_SUPPRESSION, 32'd1000);
               write_register(CSR_SLEEP_CONFIRM, 32'd50);
            end
            1: begin
               send_idle_pct = 58;
               stall_pct = 0;
               step_cap = 32'h00FF_FFFF;
               write_register(CSR_IDLE_TIMEOUT, 32'hFFFF_FFFF);
               write_register(CSR_MAX_SUPPRESSION, 32'd0);
               write_register(CSR_SLEEP_CONFIRM, 32'h7FFF_FFFF);
            end
            2: begin
               send_idle_pct = 0;
               stall_pct = 58;
               step_cap = 4;
               write_register(CSR_IDLE_TIMEOUT, 32'd1);
               write_register(CSR_MAX_SUPPRESSION, 32'd1);
               write_register(CSR_SLEEP_CONFIRM, 32'd0);
            end
            default: begin
               send_idle_pct = 26;
               stall_pct = 26;
               step_cap = 120;
               write_register(CSR_IDLE_TIMEOUT, $urandom_range(10, 400) | 32'h8000_0000);
               write_register(CSR_MAX_SUPPRESSION, $urandom_range(0, 2500));
               write_register(CSR_SLEEP_CONFIRM, $urandom_range(1, 300));
            end
         endcase
         write_register(CSR_SPARE, $urandom);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            // sender pause until everything is back
            if (p == 2 && i == PHASE_ITEMS / 2)
               drain_results();
            k = pick_kind();
            t = pick_now();
            send_event(k, t, 1'($urandom_range(0, 1)), 1'b0, QUIET);
         end
      end

      drain_results();
      repeat (8) @(posedge clock);
      if (pending_q.size() != 0)
         log_mismatch("results never delivered", pending_q.size(), '0);

      $display("%0d events over %0d register settings and four idle patterns, %0d cycles",
               sent_count, PHASES + 2, cycle_count);
      $display("predicted %0d disconnects, %0d re-arms, %0d wakes; %0d results, %0d errors",
               disconnect_seen, rearm_seen, wake_seen, checked_count, error_count);
      if (error_count == 0) begin
         $display("tb_idle_disconnect_suppression_policy_unit passed");
      end else begin
         $display("tb_idle_disconnect_suppression_policy_unit failed");
      end
      $finish;
   end

endmodule
